@@ rtl/cip_pkg.sv @@
// shared constants, codes and types of the can identifier range filter
package cip_pkg;

  localparam int unsigned MAX_RANGES = 64;
  localparam int unsigned ID_W       = 29;
  localparam int unsigned IDX_W      = (MAX_RANGES > 1) ? $clog2(MAX_RANGES) : 1;
  localparam int unsigned CNT_W      = $clog2(MAX_RANGES + 1);

  localparam int unsigned IN_DATA_W  = 88;
  localparam int unsigned OUT_DATA_W = 16;

  typedef enum logic [1:0] {
    OP_LOAD   = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_CLEAR  = 2'd2,
    OP_NONE   = 2'd3
  } cip_op_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REJECT = 2'd1,
    ST_FULL   = 2'd2
  } cip_status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SKEY,
    S_SKEYW,
    S_SRD,
    S_SCMP,
    S_SINS,
    S_CRD,
    S_CCMP,
    S_PRD,
    S_PWR,
    S_LMID,
    S_LCMP,
    S_DONE
  } cip_state_e;

  typedef struct packed {
    logic [ID_W-1:0] upper;
    logic [ID_W-1:0] lower;
  } cip_entry_t;

endpackage

@@ rtl/cip_ram.sv @@
// generic single write, single read ram with registered read data
module cip_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/can_id_range_filter.sv @@
// can identifier range acceptance filter: staging and active range tables with sort and search
//
// Each input request carries an op in tuser. A load request writes one (lower, upper) pair
// into the staging ram; the load marked by tlast then insertion-sorts the staged pairs by
// lower bound inside the staging ram, checks that every range is well formed and that no
// two overlap, and on success copies the set into the active ram. A rejected set leaves
// the active table alone; the staging table is emptied either way. A lookup binary-searches
// the active ram. Exactly one result request leaves for every input request, in order.
// A plain load, clear or unused op goes straight to its result; a lookup probes the
// active ram once per search step; a closing load runs the sort, the check and the copy
// in turn, all through the single read port of the staging ram. Both rams are undefined
// after reset and need no clearing pass: entries are only read below their count. One
// request is in work at a time; a new one is taken while the previous result still waits
// in the output register. A load into a full staging table writes nothing and reports full.
module can_id_range_filter (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // [28:0] lower_bound, [57:29] upper_bound, [86:58] search_id, [87] zero
  input  logic [cip_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  // [1:0] op
  input  logic [1:0]                     s_axis_tuser_i,
  // last_entry
  input  logic                           s_axis_tlast_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // [1:0] status, [2] found, [8:3] range_index, [15:9] active_count
  output logic [cip_pkg::OUT_DATA_W-1:0] m_axis_tdata_o
);

  localparam int unsigned IdW  = cip_pkg::ID_W;
  localparam int unsigned CntW = cip_pkg::CNT_W;
  localparam int unsigned IdxW = cip_pkg::IDX_W;
  localparam logic [CntW-1:0] MaxCnt = CntW'(cip_pkg::MAX_RANGES);

  cip_pkg::cip_state_e state_q, state_d;

  // request fields held for the whole operation
  logic [IdW-1:0]  key_q, key_d;
  // sort, check and copy counters
  logic [CntW-1:0] i_q, i_d, k_q, k_d, n_q, n_d;
  // binary search window [lo, hi) and probe
  logic [CntW-1:0] lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [CntW:0]   mid_sum;
  cip_pkg::cip_entry_t ins_q, ins_d;
  logic [IdW-1:0]  prev_hi_q, prev_hi_d;
  logic [CntW-1:0] stage_cnt_q, stage_cnt_d, range_cnt_q, range_cnt_d;
  cip_pkg::cip_status_e status_q, status_d;
  logic            found_q, found_d;
  logic [CntW-1:0] idx_q, idx_d;

  // output register
  logic                           ov_q, ov_d;
  logic [cip_pkg::OUT_DATA_W-1:0] odata_q, odata_d;

  // staging and active ram ports
  logic                st_we, ac_we;
  logic [IdxW-1:0]     st_waddr, st_raddr, ac_waddr, ac_raddr;
  cip_pkg::cip_entry_t st_wdata, ac_wdata, st_rd, ac_rd;
  logic [$bits(cip_pkg::cip_entry_t)-1:0] st_rdata, ac_rdata;

  logic s_fire;
  logic bad;
  cip_pkg::cip_op_e in_op;
  cip_pkg::cip_entry_t in_entry;

  assign s_axis_tready_o = (state_q == cip_pkg::S_IDLE);
  assign s_fire   = s_axis_tvalid_i && s_axis_tready_o;
  assign in_op    = cip_pkg::cip_op_e'(s_axis_tuser_i);
  assign in_entry = '{upper: s_axis_tdata_i[2*IdW-1:IdW], lower: s_axis_tdata_i[IdW-1:0]};
  assign st_rd    = cip_pkg::cip_entry_t'(st_rdata);
  assign ac_rd    = cip_pkg::cip_entry_t'(ac_rdata);
  assign mid_sum  = ({1'b0, lo_q} + {1'b0, hi_q} - (CntW+1)'(1)) >> 1;
  assign bad      = (st_rd.lower > st_rd.upper) ||
                    ((i_q != '0) && (st_rd.lower <= prev_hi_q));

  always_comb begin
    state_d     = state_q;
    key_d       = key_q;
    i_d         = i_q;
    k_d         = k_q;
    n_d         = n_q;
    lo_d        = lo_q;
    hi_d        = hi_q;
    mid_d       = mid_q;
    ins_d       = ins_q;
    prev_hi_d   = prev_hi_q;
    stage_cnt_d = stage_cnt_q;
    range_cnt_d = range_cnt_q;
    status_d    = status_q;
    found_d     = found_q;
    idx_d       = idx_q;
    ov_d        = ov_q && !m_axis_tready_i;
    odata_d     = odata_q;
    st_we       = 1'b0;
    st_waddr    = stage_cnt_q[IdxW-1:0];
    st_wdata    = in_entry;
    st_raddr    = i_q[IdxW-1:0];
    ac_we       = 1'b0;
    ac_waddr    = i_q[IdxW-1:0];
    ac_wdata    = st_rd;
    ac_raddr    = mid_sum[IdxW-1:0];

    unique case (state_q)
      cip_pkg::S_IDLE: begin
        if (s_fire) begin
          status_d = cip_pkg::ST_OK;
          found_d  = 1'b0;
          idx_d    = '0;
          key_d    = s_axis_tdata_i[3*IdW-1:2*IdW];
          unique case (in_op)
            cip_pkg::OP_LOAD: begin
              if (stage_cnt_q == MaxCnt) begin
                status_d = cip_pkg::ST_FULL;
                n_d      = stage_cnt_q;
              end else begin
                st_we       = 1'b1;
                stage_cnt_d = stage_cnt_q + CntW'(1);
                n_d         = stage_cnt_q + CntW'(1);
              end
              if (s_axis_tlast_i) begin
                i_d     = CntW'(1);
                state_d = cip_pkg::S_SKEY;
              end else begin
                state_d = cip_pkg::S_DONE;
              end
            end
            cip_pkg::OP_LOOKUP: begin
              lo_d    = '0;
              hi_d    = range_cnt_q;
              state_d = cip_pkg::S_LMID;
            end
            cip_pkg::OP_CLEAR: begin
              range_cnt_d = '0;
              stage_cnt_d = '0;
              state_d     = cip_pkg::S_DONE;
            end
            default: state_d = cip_pkg::S_DONE;
          endcase
        end
      end
      // insertion sort: fetch the next pair to insert
      cip_pkg::S_SKEY: begin
        if (i_q >= n_q) begin
          i_d     = '0;
          state_d = cip_pkg::S_CRD;
        end else begin
          state_d = cip_pkg::S_SKEYW;
        end
      end
      cip_pkg::S_SKEYW: begin
        ins_d   = st_rd;
        k_d     = i_q;
        state_d = cip_pkg::S_SRD;
      end
      cip_pkg::S_SRD: begin
        st_raddr = IdxW'(k_q - CntW'(1));
        state_d  = (k_q == '0) ? cip_pkg::S_SINS : cip_pkg::S_SCMP;
      end
      cip_pkg::S_SCMP: begin
        if (st_rd.lower > ins_q.lower) begin
          st_we    = 1'b1;
          st_waddr = k_q[IdxW-1:0];
          st_wdata = st_rd;
          k_d      = k_q - CntW'(1);
          state_d  = cip_pkg::S_SRD;
        end else begin
          state_d = cip_pkg::S_SINS;
        end
      end
      cip_pkg::S_SINS: begin
        st_we    = 1'b1;
        st_waddr = k_q[IdxW-1:0];
        st_wdata = ins_q;
        i_d      = i_q + CntW'(1);
        state_d  = cip_pkg::S_SKEY;
      end
      // check pass over the sorted pairs
      cip_pkg::S_CRD: begin
        if (i_q >= n_q) begin
          i_d     = '0;
          state_d = cip_pkg::S_PRD;
        end else begin
          state_d = cip_pkg::S_CCMP;
        end
      end
      cip_pkg::S_CCMP: begin
        prev_hi_d = st_rd.upper;
        if (bad) begin
          status_d    = cip_pkg::ST_REJECT;
          stage_cnt_d = '0;
          state_d     = cip_pkg::S_DONE;
        end else begin
          i_d     = i_q + CntW'(1);
          state_d = cip_pkg::S_CRD;
        end
      end
      // copy pass into the active table
      cip_pkg::S_PRD: begin
        if (i_q >= n_q) begin
          range_cnt_d = n_q;
          stage_cnt_d = '0;
          state_d     = cip_pkg::S_DONE;
        end else begin
          state_d = cip_pkg::S_PWR;
        end
      end
      cip_pkg::S_PWR: begin
        ac_we   = 1'b1;
        i_d     = i_q + CntW'(1);
        state_d = cip_pkg::S_PRD;
      end
      // binary search of the active table
      cip_pkg::S_LMID: begin
        if (lo_q < hi_q) begin
          mid_d   = mid_sum[CntW-1:0];
          state_d = cip_pkg::S_LCMP;
        end else begin
          state_d = cip_pkg::S_DONE;
        end
      end
      cip_pkg::S_LCMP: begin
        if (key_q > ac_rd.upper) begin
          lo_d    = mid_q + CntW'(1);
          state_d = cip_pkg::S_LMID;
        end else if (key_q < ac_rd.lower) begin
          hi_d    = mid_q;
          state_d = cip_pkg::S_LMID;
        end else begin
          found_d = 1'b1;
          idx_d   = mid_q;
          state_d = cip_pkg::S_DONE;
        end
      end
      cip_pkg::S_DONE: begin
        if (!ov_q || m_axis_tready_i) begin
          ov_d    = 1'b1;
          odata_d = {7'(range_cnt_q), 6'(idx_q), found_q, status_q};
          state_d = cip_pkg::S_IDLE;
        end
      end
      default: state_d = cip_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cip_pkg::S_IDLE;
      stage_cnt_q <= '0;
      range_cnt_q <= '0;
      ov_q        <= 1'b0;
    end else begin
      state_q     <= state_d;
      stage_cnt_q <= stage_cnt_d;
      range_cnt_q <= range_cnt_d;
      ov_q        <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q     <= key_d;
    i_q       <= i_d;
    k_q       <= k_d;
    n_q       <= n_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    mid_q     <= mid_d;
    ins_q     <= ins_d;
    prev_hi_q <= prev_hi_d;
    status_q  <= status_d;
    found_q   <= found_d;
    idx_q     <= idx_d;
    odata_q   <= odata_d;
  end

  assign m_axis_tvalid_o = ov_q;
  assign m_axis_tdata_o  = odata_q;

  // staging table
  cip_ram #(
    .Width ($bits(cip_pkg::cip_entry_t)),
    .Depth (cip_pkg::MAX_RANGES)
  ) u_stage_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  // active table
  cip_ram #(
    .Width ($bits(cip_pkg::cip_entry_t)),
    .Depth (cip_pkg::MAX_RANGES)
  ) u_active_ram (
    .clk_i   (clk_i),
    .we_i    (ac_we),
    .waddr_i (ac_waddr),
    .wdata_i (ac_wdata),
    .raddr_i (ac_raddr),
    .rdata_o (ac_rdata)
  );

  // counts never pass the table capacity
  a_stage_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stage_cnt_q <= MaxCnt) else $error("staging count beyond capacity");
  a_range_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    range_cnt_q <= MaxCnt) else $error("active count beyond capacity");
  // a probe always lies inside a non-empty search window
  a_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == cip_pkg::S_LCMP |-> (lo_q <= mid_q) && (mid_q < hi_q))
    else $error("search probe outside window");
  // the insertion point never runs past the pair being inserted
  a_sort: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cip_pkg::S_SCMP || state_q == cip_pkg::S_SINS) |-> (k_q <= i_q) && (i_q < n_q))
    else $error("sort index out of order");
  // the active table only changes during the copy pass
  a_copy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ac_we |-> state_q == cip_pkg::S_PWR) else $error("active write outside copy");

endmodule
